>>> hdl/kptfl_pkg.sv
// kptfl_pkg: widths, codes, types and reset values for the keypad lock controller.
// No dependencies; every other file of the block depends on this package.
package kptfl_pkg;

    localparam int MAX_PIN_KEYS  = 8;
    localparam int UID_BYTES     = 4;
    localparam int KEY_W         = 4;
    localparam int BUF_W         = MAX_PIN_KEYS * KEY_W;
    localparam int CNT_W         = $clog2(MAX_PIN_KEYS + 1);
    localparam int PIN_W         = 32;
    localparam int LEN_W         = 4;
    localparam int UID_W         = 32;
    localparam int LIMIT_W       = 4;
    localparam int FAIL_W        = 4;
    localparam int ACTION_W      = 3;
    localparam int STATUS_W      = 4;
    localparam int PHASE_W       = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int PIN_LEN_LIMIT = 8;

    // only the low min(UID_BYTES, 4) bytes of a card UID take part in the compare
    localparam int UID_CMP_BYTES = (UID_BYTES > 4) ? 4 : UID_BYTES;
    localparam logic [UID_W-1:0] UID_MASK =
        UID_W'((64'd1 << (8 * UID_CMP_BYTES)) - 64'd1);

    localparam logic [KEY_W-1:0] KEY_STAR = 4'd12;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd14;

    localparam logic [PIN_W-1:0]   RST_PIN_KEYS       = 32'd16912;
    localparam logic [LEN_W-1:0]   RST_PIN_LENGTH     = 4'd4;
    localparam logic [UID_W-1:0]   RST_AUTHORIZED_UID = 32'd0;
    localparam logic [LIMIT_W-1:0] RST_FAILURE_LIMIT  = 4'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_KEY    = 3'd0,
        ACT_FINGER = 3'd1,
        ACT_CARD   = 3'd2,
        ACT_START  = 3'd3,
        ACT_ABORT  = 3'd4,
        ACT_UNLOCK = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_KEY          = 4'd0,
        ST_CLEARED      = 4'd1,
        ST_PIN_OK       = 4'd2,
        ST_PIN_WRONG    = 4'd3,
        ST_SECOND       = 4'd4,
        ST_GRANTED      = 4'd5,
        ST_FINGER_WRONG = 4'd6,
        ST_CARD_WRONG   = 4'd7,
        ST_LOCKED       = 4'd8,
        ST_UNLOCKED     = 4'd9,
        ST_IGNORED      = 4'd10
    } t_status;

    typedef enum logic [PHASE_W-1:0] {
        PH_STANDBY = 2'd0,
        PH_PIN     = 2'd1,
        PH_SECOND  = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIN_KEYS       = 2'd0,
        CFG_PIN_LENGTH     = 2'd1,
        CFG_AUTHORIZED_UID = 2'd2,
        CFG_FAILURE_LIMIT  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [PIN_W-1:0]   pin_keys;
        logic [LEN_W-1:0]   pin_length;
        logic [UID_W-1:0]   authorized_uid;
        logic [LIMIT_W-1:0] failure_limit;
    } t_cfg;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key_code;
        logic                finger_match;
        logic [UID_W-1:0]    card_uid;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                open_gate;
        logic                locked;
        logic [FAIL_W-1:0]   failures;
        logic [PHASE_W-1:0]  phase;
        logic [CNT_W-1:0]    entered_keys;
    } t_result;

    typedef struct packed {
        logic [BUF_W-1:0] keys;
        logic [CNT_W-1:0] cnt;
        logic             ovf;
    } t_pin_buf;

endpackage

>>> hdl/kptfl_if.sv
// kptfl_if: valid/ready channel interfaces for events, results and config writes.
// Depends on kptfl_pkg for field widths.
interface kptfl_item_if;
    logic                             valid;
    logic                             ready;
    logic [kptfl_pkg::ACTION_W-1:0]   action;
    logic [kptfl_pkg::KEY_W-1:0]      key_code;
    logic                             finger_match;
    logic [kptfl_pkg::UID_W-1:0]      card_uid;

    modport source (output valid, action, key_code, finger_match, card_uid, input ready);
    modport sink   (input valid, action, key_code, finger_match, card_uid, output ready);
endinterface

interface kptfl_result_if;
    logic                             valid;
    logic                             ready;
    logic [kptfl_pkg::STATUS_W-1:0]   status;
    logic                             open_gate;
    logic                             locked;
    logic [kptfl_pkg::FAIL_W-1:0]     failures;
    logic [kptfl_pkg::PHASE_W-1:0]    phase;
    logic [kptfl_pkg::CNT_W-1:0]      entered_keys;

    modport source (output valid, status, open_gate, locked, failures, phase, entered_keys,
                    input ready);
    modport sink   (input valid, status, open_gate, locked, failures, phase, entered_keys,
                    output ready);
endinterface

interface kptfl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [kptfl_pkg::CFG_IDX_W-1:0]  index;
    logic [kptfl_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/kptfl_cfg.sv
// kptfl_cfg: configuration register file written over the config channel.
// Depends on kptfl_pkg and kptfl_cfg_if.
module kptfl_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kptfl_cfg_if.sink         i_cfg,
    output kptfl_pkg::t_cfg   o_cfg
);
    import kptfl_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PIN_KEYS:       n_cfg.pin_keys       = i_cfg.data[PIN_W-1:0];
                CFG_PIN_LENGTH:     n_cfg.pin_length     = i_cfg.data[LEN_W-1:0];
                CFG_AUTHORIZED_UID: n_cfg.authorized_uid = i_cfg.data[UID_W-1:0];
                CFG_FAILURE_LIMIT:  n_cfg.failure_limit  = i_cfg.data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_keys       <= RST_PIN_KEYS;
            r_cfg.pin_length     <= RST_PIN_LENGTH;
            r_cfg.authorized_uid <= RST_AUTHORIZED_UID;
            r_cfg.failure_limit  <= RST_FAILURE_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/kptfl_engine.sv
// kptfl_engine: lock state (PIN buffers, phase, failure count, lock flag) and the
// combinational decision logic for one event. Depends on kptfl_pkg.
module kptfl_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  kptfl_pkg::t_item    i_item,
    input  kptfl_pkg::t_cfg     i_cfg,
    output kptfl_pkg::t_result  o_result
);
    import kptfl_pkg::*;

    t_pin_buf          r_sby, n_sby;
    t_pin_buf          r_fac, n_fac;
    t_phase            r_phase, n_phase;
    logic [FAIL_W-1:0] r_fail, n_fail;
    logic              r_lock, n_lock;

    t_phase            v_phase;
    logic [FAIL_W-1:0] v_fail_inc;
    logic              v_fail_lock;
    t_status           v_status;
    logic              v_gate;

    localparam t_pin_buf BUF_EMPTY = '0;

    function automatic t_pin_buf buf_push(t_pin_buf b, logic [KEY_W-1:0] key);
        t_pin_buf nb;
        nb = b;
        if (b.cnt < CNT_W'(MAX_PIN_KEYS)) begin
            for (int i = 0; i < MAX_PIN_KEYS; i++) begin
                if (b.cnt == CNT_W'(i)) nb.keys[i*KEY_W +: KEY_W] = key;
            end
            nb.cnt = b.cnt + 1'b1;
        end else begin
            nb.ovf = 1'b1;
        end
        return nb;
    endfunction

    function automatic logic pin_match(t_pin_buf b, t_cfg c);
        logic eq;
        eq = !b.ovf && (c.pin_length != '0) &&
             (8'(c.pin_length) <= 8'(PIN_LEN_LIMIT)) &&
             (8'(b.cnt) == 8'(c.pin_length));
        for (int i = 0; i < MAX_PIN_KEYS; i++) begin
            if ((8'(i) < 8'(c.pin_length)) &&
                (b.keys[i*KEY_W +: KEY_W] != c.pin_keys[i*KEY_W +: KEY_W])) eq = 1'b0;
        end
        return eq;
    endfunction

    always_comb begin
        n_sby    = r_sby;
        n_fac    = r_fac;
        n_fail   = r_fail;
        n_lock   = r_lock;
        v_status = ST_IGNORED;
        v_gate   = 1'b0;

        // unreachable phase code behaves as standby
        case (r_phase)
            PH_PIN:    v_phase = PH_PIN;
            PH_SECOND: v_phase = PH_SECOND;
            default:   v_phase = PH_STANDBY;
        endcase
        n_phase = v_phase;

        v_fail_inc  = (r_fail != '1) ? r_fail + 1'b1 : r_fail;
        v_fail_lock = r_lock || (v_fail_inc >= i_cfg.failure_limit);

        if ((i_item.action == ACT_START || i_item.action == ACT_ABORT ||
             i_item.action == ACT_UNLOCK) && v_phase != PH_STANDBY) begin
            n_phase = PH_STANDBY;
        end else begin
            case (i_item.action)
                ACT_KEY: begin
                    case (v_phase)
                        PH_STANDBY: begin
                            if (r_lock) begin
                                v_status = ST_LOCKED;
                            end else if (i_item.key_code == KEY_HASH) begin
                                n_sby    = BUF_EMPTY;
                                v_status = ST_CLEARED;
                            end else if (i_item.key_code == KEY_STAR) begin
                                if (pin_match(r_sby, i_cfg)) begin
                                    v_status = ST_PIN_OK;
                                end else begin
                                    n_fail   = v_fail_inc;
                                    n_lock   = v_fail_lock;
                                    v_status = ST_PIN_WRONG;
                                end
                                n_sby = BUF_EMPTY;
                            end else begin
                                n_sby    = buf_push(r_sby, i_item.key_code);
                                v_status = ST_KEY;
                            end
                        end
                        PH_PIN: begin
                            if (i_item.key_code == KEY_HASH) begin
                                n_fac    = BUF_EMPTY;
                                v_status = ST_CLEARED;
                            end else if (i_item.key_code == KEY_STAR) begin
                                if (pin_match(r_fac, i_cfg)) begin
                                    n_phase  = PH_SECOND;
                                    v_status = ST_SECOND;
                                end else begin
                                    n_fail   = v_fail_inc;
                                    n_lock   = v_fail_lock;
                                    v_status = ST_PIN_WRONG;
                                    if (v_fail_lock) n_phase = PH_STANDBY;
                                end
                                n_fac = BUF_EMPTY;
                            end else begin
                                n_fac    = buf_push(r_fac, i_item.key_code);
                                v_status = ST_KEY;
                            end
                        end
                        default: ;
                    endcase
                end
                ACT_FINGER: begin
                    if (v_phase == PH_SECOND) begin
                        if (i_item.finger_match) begin
                            n_fail   = '0;
                            v_gate   = 1'b1;
                            v_status = ST_GRANTED;
                            n_phase  = PH_STANDBY;
                        end else begin
                            n_fail   = v_fail_inc;
                            n_lock   = v_fail_lock;
                            v_status = ST_FINGER_WRONG;
                            if (v_fail_lock) n_phase = PH_STANDBY;
                        end
                    end
                end
                ACT_CARD: begin
                    if (v_phase == PH_SECOND) begin
                        if ((i_item.card_uid & UID_MASK) ==
                            (i_cfg.authorized_uid & UID_MASK)) begin
                            n_fail   = '0;
                            v_gate   = 1'b1;
                            v_status = ST_GRANTED;
                        end else begin
                            n_fail   = v_fail_inc;
                            n_lock   = v_fail_lock;
                            v_status = ST_CARD_WRONG;
                        end
                        n_phase = PH_STANDBY;
                    end
                end
                ACT_START: begin
                    if (r_lock) begin
                        v_status = ST_LOCKED;
                    end else begin
                        n_fac    = BUF_EMPTY;
                        n_phase  = PH_PIN;
                        v_status = ST_CLEARED;
                    end
                end
                ACT_UNLOCK: begin
                    n_lock   = 1'b0;
                    n_fail   = '0;
                    v_status = ST_UNLOCKED;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_result.status       = v_status;
        o_result.open_gate    = v_gate;
        o_result.locked       = n_lock;
        o_result.failures     = n_fail;
        o_result.phase        = n_phase;
        o_result.entered_keys = (n_phase == PH_STANDBY) ? n_sby.cnt : n_fac.cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sby   <= BUF_EMPTY;
            r_fac   <= BUF_EMPTY;
            r_phase <= PH_STANDBY;
            r_fail  <= '0;
            r_lock  <= 1'b0;
        end else if (i_en) begin
            r_sby   <= n_sby;
            r_fac   <= n_fac;
            r_phase <= n_phase;
            r_fail  <= n_fail;
            r_lock  <= n_lock;
        end
    end

endmodule

>>> hdl/keypad_two_factor_lock_controller_core.sv
// keypad_two_factor_lock_controller_core: top level of the keypad PIN lock with a
// two-factor flow and lockout. Depends on kptfl_pkg, kptfl_if, kptfl_cfg, kptfl_engine.
//
// Each event transaction on i_item (key press, fingerprint result, card read, start of
// the two-factor flow, abort, unlock override) yields exactly one result transaction on
// o_result, in order. Throughput is one transaction per clock while o_result.ready stays
// high. The accepting edge loads the event input register; the event then moves into the
// result register, which raises o_result.valid, once that register is empty or
// o_result.ready is high. The whole decision (PIN compare, UID compare, failure count and
// lock update) is combinational between the two registers. The result register lets a new
// event enter while a result waits for o_result.ready. Configuration writes on i_cfg
// (index 0 PIN keys, 1 PIN length, 2 authorized UID, 3 failure limit) are always ready and
// are meant to be issued only while no event is in flight. Reset is synchronous, active
// low, and restores the power-on PIN 0124, length 4, UID 0, limit 3.
module keypad_two_factor_lock_controller_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kptfl_cfg_if.sink     i_cfg,
    kptfl_item_if.sink    i_item,
    kptfl_result_if.source o_result
);
    import kptfl_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;

    // event input register
    logic    r_in_vld;
    t_item   r_in;

    // result register
    logic    r_out_vld;
    t_result r_out;

    logic    w_adv;    // registered event moves into the result register
    logic    w_take;   // event transaction accepted this cycle

    assign w_adv  = r_in_vld && (!r_out_vld || o_result.ready);
    assign w_take = i_item.valid && i_item.ready;

    assign i_item.ready = !r_in_vld || w_adv;

    kptfl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // lock state commits only when its result is captured
    kptfl_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_in_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.action       <= i_item.action;
            r_in.key_code     <= i_item.key_code;
            r_in.finger_match <= i_item.finger_match;
            r_in.card_uid     <= i_item.card_uid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || o_result.ready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid        = r_out_vld;
    assign o_result.status       = r_out.status;
    assign o_result.open_gate    = r_out.open_gate;
    assign o_result.locked       = r_out.locked;
    assign o_result.failures     = r_out.failures;
    assign o_result.phase        = r_out.phase;
    assign o_result.entered_keys = r_out.entered_keys;

    // a grant always clears the count and returns to standby
    a_grant_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.open_gate) |->
            (o_result.failures == '0 && o_result.phase == PH_STANDBY &&
             o_result.status == ST_GRANTED))
        else $error("grant without count clear or standby return");

    // the two-factor flow never runs while locked
    a_flow_unlocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.phase != PH_STANDBY) |-> !o_result.locked)
        else $error("two-factor phase reported while locked");

    // a stalled event stays in the input register
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> r_in_vld)
        else $error("event lost from input register");

    // key count never exceeds buffer depth
    a_keys_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.entered_keys <= CNT_W'(MAX_PIN_KEYS)))
        else $error("entered key count beyond buffer depth");

endmodule
